// ===== rtl/qhpc_pkg.sv =====
// shared types and constants for the quaternion heading controller
// no dependencies; every other file depends on this package
package qhpc_pkg;

  // iterations of the vectoring cordic, capped at the angle table length
  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_LEN     = 24;
  localparam int NSTEPS       = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;

  // field widths
  localparam int QW       = 16;  // quaternion component, q1.15
  localparam int GAIN_W   = 15;  // gains, q3.12 unsigned
  localparam int HEAD_W   = 16;  // heading, q3.13
  localparam int SPEED_W  = 16;  // forward speed, q2.14
  localparam int TURN_W   = 15;  // turn rate, q4.11
  localparam int CFG_IW   = 2;
  localparam int CFG_DW   = 16;

  // internal widths
  localparam int PROD_W   = 2 * QW;   // one 16x16 product
  localparam int VW       = 38;       // cordic vector, covers gain growth of 2^34 inputs
  localparam int AW       = 20;       // cordic angle, radians q.16
  localparam int YAW_W    = 18;
  localparam int ERR_W    = 18;       // raw heading error before wrap
  localparam int TPROD_W  = 32;       // gain times wrapped error, q.25

  localparam logic signed [AW-1:0]     PI_Q16     = AW'(205887);
  localparam logic signed [ERR_W-1:0]  PI_Q13     = ERR_W'(25736);
  localparam logic signed [ERR_W-1:0]  TWO_PI_Q13 = ERR_W'(51472);
  localparam logic signed [TPROD_W-1:0] TURN_RND  = TPROD_W'(8192);
  localparam logic signed [YAW_W-1:0]  TURN_LIMIT = YAW_W'(10240);
  localparam logic [SPEED_W-1:0]       SPEED_LIMIT = SPEED_W'(16384);
  localparam logic signed [VW-1:0]     ONE_Q30    = VW'(64'sd1073741824);

  localparam logic [GAIN_W-1:0] LINEAR_GAIN_RST = GAIN_W'(3277);
  localparam logic [GAIN_W-1:0] TURN_GAIN_RST   = GAIN_W'(6144);
  localparam logic [HEAD_W-1:0] TARGET_RST      = '0;

  // atan(2^-i) in radians, q.16
  localparam logic signed [AW-1:0] ATAN_TAB [ATAN_LEN] = '{
    AW'(51472), AW'(30386), AW'(16055), AW'(8150), AW'(4091), AW'(2047),
    AW'(1024),  AW'(512),   AW'(256),   AW'(128),  AW'(64),   AW'(32),
    AW'(16),    AW'(8),     AW'(4),     AW'(2),    AW'(1),    AW'(0),
    AW'(0),     AW'(0),     AW'(0),     AW'(0),    AW'(0),    AW'(0)
  };

  typedef enum logic [CFG_IW-1:0] {
    REG_LINEAR_GAIN    = 2'd0,
    REG_TURN_GAIN      = 2'd1,
    REG_TARGET_HEADING = 2'd2
  } reg_idx_t;

  // one cordic pipeline slot
  typedef struct packed {
    logic                 vld;
    logic                 zero;  // yaw vector was exactly zero
    logic signed [VW-1:0] vx;
    logic signed [VW-1:0] vy;
    logic signed [AW-1:0] ang;
  } cvec_t;

endpackage

// ===== rtl/qhpc_if.sv =====
// channel interfaces: quaternion samples in, motion commands out, register writes
// depends on qhpc_pkg for field widths
interface qhpc_quat_if;
  logic                              valid;
  logic                              ready;
  logic signed [qhpc_pkg::QW-1:0]    quat_w;
  logic signed [qhpc_pkg::QW-1:0]    quat_x;
  logic signed [qhpc_pkg::QW-1:0]    quat_y;
  logic signed [qhpc_pkg::QW-1:0]    quat_z;
  modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface qhpc_cmd_if;
  logic                                valid;
  logic                                ready;
  logic signed [qhpc_pkg::SPEED_W-1:0] forward_speed;
  logic signed [qhpc_pkg::TURN_W-1:0]  turn_rate;
  logic                                turn_saturated;
  modport source (output valid, forward_speed, turn_rate, turn_saturated, input ready);
  modport sink   (input valid, forward_speed, turn_rate, turn_saturated, output ready);
endinterface

interface qhpc_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [qhpc_pkg::CFG_IW-1:0]        index;
  logic [qhpc_pkg::CFG_DW-1:0]        wdata;
  modport source (output valid, index, wdata, input ready);
  modport sink   (input valid, index, wdata, output ready);
endinterface

// ===== rtl/quaternion_heading_p_controller.sv =====
// quaternion heading controller: yaw from a pipelined cordic, p-control of turn rate
// pipeline registers: two for the yaw terms,
// one per cordic step, four for error, wrap, gain multiply and clamp
// throughput one sample per cycle; a stalled output freezes the whole pipeline
// synchronous reset empties the pipeline and loads the default gains and target
// depends on qhpc_pkg, qhpc_if, qhpc_yaw_terms, qhpc_cordic, qhpc_steer
module quaternion_heading_p_controller (
  input  logic        clk,
  input  logic        rst,
  qhpc_quat_if.sink   sample,
  qhpc_cmd_if.source  command,
  qhpc_cfg_if.sink    cfg
);
  import qhpc_pkg::*;

  logic                       en;
  logic                       out_vld;
  logic [GAIN_W-1:0]          turn_gain;
  logic signed [HEAD_W-1:0]   target_heading;
  logic [SPEED_W-1:0]         speed_cmd;
  logic [GAIN_W-1:0]          lin_wr;
  cvec_t                      vec_pre, vec_post;

  // everything moves together unless a finished command is held back
  assign en            = !out_vld || command.ready;
  assign sample.ready  = en;
  assign command.valid = out_vld;
  assign cfg.ready     = 1'b1;

  // forward speed only depends on the linear gain, so it is set at the write
  assign lin_wr = cfg.wdata[GAIN_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      turn_gain      <= TURN_GAIN_RST;
      target_heading <= TARGET_RST;
      speed_cmd      <= (LINEAR_GAIN_RST[GAIN_W-1:12] != '0) ? SPEED_LIMIT
                        : SPEED_W'({LINEAR_GAIN_RST[11:0], 2'b00});
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_LINEAR_GAIN: begin
          speed_cmd <= (lin_wr[GAIN_W-1:12] != '0) ? SPEED_LIMIT
                       : SPEED_W'({lin_wr[11:0], 2'b00});
        end
        REG_TURN_GAIN:      turn_gain      <= cfg.wdata[GAIN_W-1:0];
        REG_TARGET_HEADING: target_heading <= cfg.wdata;
        default: ;
      endcase
    end
  end

  qhpc_yaw_terms u_terms (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .in_vld (sample.valid),
    .qw     (sample.quat_w),
    .qx     (sample.quat_x),
    .qy     (sample.quat_y),
    .qz     (sample.quat_z),
    .vec    (vec_pre)
  );

  qhpc_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .vec_in  (vec_pre),
    .vec_out (vec_post)
  );

  qhpc_steer u_steer (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .vec            (vec_post),
    .turn_gain      (turn_gain),
    .target_heading (target_heading),
    .out_vld        (out_vld),
    .turn_rate      (command.turn_rate),
    .turn_saturated (command.turn_saturated)
  );

  assign command.forward_speed = speed_cmd;

endmodule

// ===== rtl/qhpc_yaw_terms.sv =====
// yaw terms from the quaternion: products, then s/c and the half-plane pre-rotation
// depends on qhpc_pkg; feeds qhpc_cordic
module qhpc_yaw_terms (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_vld,
  input  logic signed [qhpc_pkg::QW-1:0]  qw,
  input  logic signed [qhpc_pkg::QW-1:0]  qx,
  input  logic signed [qhpc_pkg::QW-1:0]  qy,
  input  logic signed [qhpc_pkg::QW-1:0]  qz,
  output qhpc_pkg::cvec_t                 vec
);
  import qhpc_pkg::*;

  logic                     p_vld;
  logic signed [PROD_W-1:0] p_wz, p_xy, p_yy, p_zz;
  logic signed [VW-1:0]     s_w, c_w;
  cvec_t                    vec_next;

  // stage 1: the four products
  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else if (en) begin
      p_vld <= in_vld;
    end
    if (en) begin
      p_wz <= PROD_W'(qw) * PROD_W'(qz);
      p_xy <= PROD_W'(qx) * PROD_W'(qy);
      p_yy <= PROD_W'(qy) * PROD_W'(qy);
      p_zz <= PROD_W'(qz) * PROD_W'(qz);
    end
  end

  // stage 2: s = 2(wz+xy), c = 1 - 2(y^2+z^2), folded into the right half plane
  always_comb begin
    s_w = (VW'(p_wz) + VW'(p_xy)) <<< 1;
    c_w = ONE_Q30 - ((VW'(p_yy) + VW'(p_zz)) <<< 1);
    vec_next.vld  = p_vld;
    vec_next.zero = (s_w == '0) && (c_w == '0);
    if (c_w < 0) begin
      vec_next.vx  = -c_w;
      vec_next.vy  = -s_w;
      vec_next.ang = (s_w >= 0) ? PI_Q16 : -PI_Q16;
    end else begin
      vec_next.vx  = c_w;
      vec_next.vy  = s_w;
      vec_next.ang = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vec.vld <= 1'b0;
    end else if (en) begin
      vec.vld <= vec_next.vld;
    end
    if (en) begin
      vec.zero <= vec_next.zero;
      vec.vx   <= vec_next.vx;
      vec.vy   <= vec_next.vy;
      vec.ang  <= vec_next.ang;
    end
  end

endmodule

// ===== rtl/qhpc_cordic.sv =====
// vectoring cordic, one registered micro-rotation per stage
// depends on qhpc_pkg (angle table, step count, slot type)
module qhpc_cordic (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  qhpc_pkg::cvec_t vec_in,
  output qhpc_pkg::cvec_t vec_out
);
  import qhpc_pkg::*;

  cvec_t stg [NSTEPS+1];

  assign stg[0]  = vec_in;
  assign vec_out = stg[NSTEPS];

  for (genvar i = 0; i < NSTEPS; i++) begin : g_step
    cvec_t nxt;

    always_comb begin
      nxt = stg[i];
      if (stg[i].vy > 0) begin
        nxt.vx  = stg[i].vx + (stg[i].vy >>> i);
        nxt.vy  = stg[i].vy - (stg[i].vx >>> i);
        nxt.ang = stg[i].ang + ATAN_TAB[i];
      end else begin
        nxt.vx  = stg[i].vx - (stg[i].vy >>> i);
        nxt.vy  = stg[i].vy + (stg[i].vx >>> i);
        nxt.ang = stg[i].ang - ATAN_TAB[i];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        stg[i+1].vld <= 1'b0;
      end else if (en) begin
        stg[i+1].vld <= nxt.vld;
      end
      if (en) begin
        stg[i+1].zero <= nxt.zero;
        stg[i+1].vx   <= nxt.vx;
        stg[i+1].vy   <= nxt.vy;
        stg[i+1].ang  <= nxt.ang;
      end
    end
  end

endmodule

// ===== rtl/qhpc_steer.sv =====
// heading error, wrap to [-pi, pi), gain multiply, rounding and clamp
// depends on qhpc_pkg; last stage is the command output register
module qhpc_steer (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  qhpc_pkg::cvec_t                     vec,
  input  logic [qhpc_pkg::GAIN_W-1:0]         turn_gain,
  input  logic signed [qhpc_pkg::HEAD_W-1:0]  target_heading,
  output logic                                out_vld,
  output logic signed [qhpc_pkg::TURN_W-1:0]  turn_rate,
  output logic                                turn_saturated
);
  import qhpc_pkg::*;

  logic                      e_vld, w_vld, m_vld;
  logic signed [YAW_W-1:0]   yaw;
  logic signed [ERR_W-1:0]   err, err_next;
  logic signed [HEAD_W-1:0]  werr, werr_next;
  logic signed [TPROD_W-1:0] tprod, rnd;
  logic signed [YAW_W-1:0]   turn;

  // yaw rounded from q.16 to q3.13; zero vector reads as zero yaw
  always_comb begin
    yaw      = vec.zero ? '0 : YAW_W'((AW'(vec.ang) + AW'(4)) >>> 3);
    err_next = ERR_W'(target_heading) - ERR_W'(yaw);
  end

  // error stays within one turn of the range, so one correction suffices
  always_comb begin
    priority if (err >= PI_Q13) begin
      werr_next = HEAD_W'(err - TWO_PI_Q13);
    end else if (err < -PI_Q13) begin
      werr_next = HEAD_W'(err + TWO_PI_Q13);
    end else begin
      werr_next = HEAD_W'(err);
    end
  end

  always_comb begin
    rnd  = tprod + TURN_RND;
    turn = YAW_W'(rnd >>> 14);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld   <= 1'b0;
      w_vld   <= 1'b0;
      m_vld   <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      e_vld   <= vec.vld;
      w_vld   <= e_vld;
      m_vld   <= w_vld;
      out_vld <= m_vld;
    end
    if (en) begin
      err   <= err_next;
      werr  <= werr_next;
      tprod <= TPROD_W'($signed({1'b0, turn_gain})) * TPROD_W'(werr);
      priority if (turn > TURN_LIMIT) begin
        turn_rate      <= TURN_W'(TURN_LIMIT);
        turn_saturated <= 1'b1;
      end else if (turn < -TURN_LIMIT) begin
        turn_rate      <= TURN_W'(-TURN_LIMIT);
        turn_saturated <= 1'b1;
      end else begin
        turn_rate      <= TURN_W'(turn);
        turn_saturated <= 1'b0;
      end
    end
  end

endmodule
